### sv/sync_length_checksum_packet_parser_top_assert.svh
// assertion macros for the deframer top module
`ifndef SYNC_LENGTH_CHECKSUM_PACKET_PARSER_TOP_ASSERT_SVH
`define SYNC_LENGTH_CHECKSUM_PACKET_PARSER_TOP_ASSERT_SVH

// checked only out of reset
`define SLCP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define SLCP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### sv/slcp_pkg.sv
`timescale 1ns / 1ps

package slcp_pkg;

    localparam logic [7:0] SYNC_BYTE_RESET = 8'h42;

    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic [7:0] byte_index;
        logic       frame_done;
        logic       checksum_ok;
        logic [7:0] frame_length;
    } t_result;

endpackage

### sv/slcp_core.sv
`timescale 1ns / 1ps

module slcp_core
    import slcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_sync_byte,
    output t_result    o_result
);

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_LEN  = 3'd1,
        PH_DATA = 3'd2,
        PH_CHI  = 3'd3,
        PH_CLO  = 3'd4
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_expected_length, n_expected_length;
    logic [7:0]  r_bytes_received, n_bytes_received;
    logic [15:0] r_running_sum, n_running_sum;
    logic [7:0]  r_checksum_high, n_checksum_high;
    logic [7:0]  w_count_inc;

    assign w_count_inc = r_bytes_received + 8'd1;

    always_comb begin
        n_phase           = r_phase;
        n_expected_length = r_expected_length;
        n_bytes_received  = r_bytes_received;
        n_running_sum     = r_running_sum;
        n_checksum_high   = r_checksum_high;
        o_result          = '0;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == i_sync_byte) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_expected_length = i_rx_byte;
                n_bytes_received  = '0;
                n_running_sum     = '0;
                n_phase           = (i_rx_byte != 8'd0) ? PH_DATA : PH_CHI;
            end
            PH_DATA: begin
                o_result.data_valid = 1'b1;
                o_result.data_byte  = i_rx_byte;
                o_result.byte_index = r_bytes_received;
                n_running_sum       = r_running_sum + {8'd0, i_rx_byte};
                n_bytes_received    = w_count_inc;
                if (w_count_inc == r_expected_length) begin
                    n_phase = PH_CHI;
                end
            end
            PH_CHI: begin
                n_checksum_high = i_rx_byte;
                n_phase         = PH_CLO;
            end
            PH_CLO: begin
                o_result.frame_done   = 1'b1;
                o_result.checksum_ok  = ({r_checksum_high, i_rx_byte} == r_running_sum);
                o_result.frame_length = r_bytes_received;
                n_phase               = PH_HUNT;
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_HUNT;
            r_expected_length <= '0;
            r_bytes_received  <= '0;
            r_running_sum     <= '0;
            r_checksum_high   <= '0;
        end else if (i_step) begin
            r_phase           <= n_phase;
            r_expected_length <= n_expected_length;
            r_bytes_received  <= n_bytes_received;
            r_running_sum     <= n_running_sum;
            r_checksum_high   <= n_checksum_high;
        end
    end

endmodule

### sv/sync_length_checksum_packet_parser_top.sv
// Byte stream deframer: sync byte, length byte, payload, 16-bit big-endian sum.
// Input channel: i_valid / o_stall carry one received byte (i_rx_byte) per beat.
// Output channel: o_valid / i_stall carry one result beat for every input beat:
//   payload bytes come out with data_valid and their index in the frame, the
//   low checksum byte gives frame_done with frame_length and checksum_ok, and
//   every other byte gives an all-zero result.
// Path: each input beat is held in the input register, then the result register
//   takes the result beat after the frame state machine.
// Throughput: one beat per cycle while the receiver does not stall.
// The sync byte register is written with i_sync_byte_we / i_sync_byte; the user
//   must do so only while the block is idle, which the block does not enforce; it holds 0x42 after reset.
// Reset (synchronous, active low) empties both registers and returns the
//   parser to hunting for sync.
// When the receiver stalls, the result register holds its beat; one more input
//   beat is taken into the input register if it is empty, then o_stall rises until the result
//   is taken.
`timescale 1ns / 1ps

module sync_length_checksum_packet_parser_top
    import slcp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_sync_byte_we,
    input  logic [7:0] i_sync_byte,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_data_valid,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_byte_index,
    output logic       o_frame_done,
    output logic       o_checksum_ok,
    output logic [7:0] o_frame_length
);

    logic [7:0] r_sync_byte;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_adv;
    logic       w_in_acc;
    logic       w_step;

    assign w_adv    = !r_out_valid || !i_stall;
    assign o_stall  = r_in_valid && !w_adv;
    assign w_in_acc = i_valid && !o_stall;
    assign w_step   = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_byte <= SYNC_BYTE_RESET;
        end else if (i_sync_byte_we) begin
            r_sync_byte <= i_sync_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_byte <= i_rx_byte;
        end
    end

    slcp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_rx_byte   (r_in_byte),
        .i_sync_byte (r_sync_byte),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_data_valid   = r_out.data_valid;
    assign o_data_byte    = r_out.data_byte;
    assign o_byte_index   = r_out.byte_index;
    assign o_frame_done   = r_out.frame_done;
    assign o_checksum_ok  = r_out.checksum_ok;
    assign o_frame_length = r_out.frame_length;

`include "sync_length_checksum_packet_parser_top_assert.svh"

    // a payload beat and a frame end never share one result
    `SLCP_ASSERT(a_done_not_data, r_out_valid |-> !(r_out.data_valid && r_out.frame_done), "payload and frame end in one beat")

    // frame fields are zero outside a frame end
    `SLCP_ASSERT(a_frame_fields_zero, (r_out_valid && !r_out.frame_done) |-> (!r_out.checksum_ok && r_out.frame_length == 8'd0), "frame fields set without frame end")

    // a held input byte moves into the result register next cycle when free
    `SLCP_ASSERT(a_in_to_out, (r_in_valid && w_adv) |=> r_out_valid, "input beat lost")

    // a stalled input register keeps its byte
    `SLCP_ASSERT(a_in_hold, (r_in_valid && o_stall) |=> (r_in_valid && $stable(r_in_byte)), "held input beat changed")

    // nothing is pending right after reset
    `SLCP_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (!r_in_valid && !r_out_valid), "pipeline not empty after reset")

endmodule

### tb/sync_length_checksum_packet_parser_top_tb.sv
`timescale 1ns / 1ps

module sync_length_checksum_packet_parser_top_tb;
    import slcp_pkg::*;

    typedef enum logic [2:0] {
        HUNT_SYNC,
        GET_LENGTH,
        GET_PAYLOAD,
        GET_SUM_HI,
        GET_SUM_LO
    } t_deframe_phase;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_sync_byte_we;
    logic [7:0] i_sync_byte;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic       o_data_valid;
    logic [7:0] o_data_byte;
    logic [7:0] o_byte_index;
    logic       o_frame_done;
    logic       o_checksum_ok;
    logic [7:0] o_frame_length;

    // deframer state as seen by the predictor
    t_deframe_phase parse_phase   = HUNT_SYNC;
    logic [7:0]     sync_value    = SYNC_BYTE_RESET;
    logic [7:0]     frame_len_exp = 8'h00;
    logic [7:0]     payload_count = 8'h00;
    logic [15:0]    payload_sum   = 16'h0000;
    logic [7:0]     csum_hi       = 8'h00;

    t_result expected_q[$];
    int      err_count     = 0;
    int      sent_count    = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    sync_length_checksum_packet_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sync_byte_we (i_sync_byte_we),
        .i_sync_byte    (i_sync_byte),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_rx_byte      (i_rx_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_data_valid   (o_data_valid),
        .o_data_byte    (o_data_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_done   (o_frame_done),
        .o_checksum_ok  (o_checksum_ok),
        .o_frame_length (o_frame_length)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    function automatic t_result deframe_byte(input logic [7:0] b);
        t_result r;
        r = '0;
        unique case (parse_phase)
            HUNT_SYNC: begin
                if (b == sync_value) parse_phase = GET_LENGTH;
            end
            GET_LENGTH: begin
                frame_len_exp = b;
                payload_count = 8'h00;
                payload_sum   = 16'h0000;
                if (b != 8'h00) parse_phase = GET_PAYLOAD;
                else parse_phase = GET_SUM_HI;
            end
            GET_PAYLOAD: begin
                r.data_valid  = 1'b1;
                r.data_byte   = b;
                r.byte_index  = payload_count;
                payload_sum   = payload_sum + {8'h00, b};
                payload_count = payload_count + 8'h01;
                if (payload_count == frame_len_exp) parse_phase = GET_SUM_HI;
            end
            GET_SUM_HI: begin
                csum_hi     = b;
                parse_phase = GET_SUM_LO;
            end
            GET_SUM_LO: begin
                r.frame_done   = 1'b1;
                r.checksum_ok  = ({csum_hi, b} == payload_sum);
                r.frame_length = payload_count;
                parse_phase    = HUNT_SYNC;
            end
            default: begin
                parse_phase = HUNT_SYNC;
            end
        endcase
        return r;
    endfunction

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall == 1'b0) begin
            got = {o_data_valid, o_data_byte, o_byte_index,
                   o_frame_done, o_checksum_ok, o_frame_length};
            if (expected_q.size() == 0) begin
                report_error("result beat with nothing expected");
            end else begin
                want = expected_q.pop_front();
                check_field("data_valid", 8'(got.data_valid), 8'(want.data_valid));
                check_field("data_byte", got.data_byte, want.data_byte);
                check_field("byte_index", got.byte_index, want.byte_index);
                check_field("frame_done", 8'(got.frame_done), 8'(want.frame_done));
                check_field("checksum_ok", 8'(got.checksum_ok), 8'(want.checksum_ok));
                check_field("frame_length", got.frame_length, want.frame_length);
            end
        end
    end

    // called at a falling edge; returns at the falling edge after the beat is taken
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        expected_q.push_back(deframe_byte(b));
        sent_count++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_sync_byte(input logic [7:0] value);
        wait_idle();
        i_sync_byte_we <= 1'b1;
        i_sync_byte    <= value;
        @(negedge i_clk);
        i_sync_byte_we <= 1'b0;
        sync_value = value;
    endtask

    task automatic send_frame(input int len, input bit corrupt);
        logic [15:0] sum;
        logic [7:0]  b;
        sum = 16'h0000;
        send_byte(sync_value);
        send_byte(8'(len));
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(0, 255));
            sum = sum + {8'h00, b};
            send_byte(b);
        end
        if (corrupt) sum = sum ^ (16'h0001 << $urandom_range(0, 15));
        send_byte(sum[15:8]);
        send_byte(sum[7:0]);
    endtask

    // noise while hunting, empty frames, payload holding 0xff and the sync byte,
    // bad checksum
    task automatic test_directed_frames();
        logic [7:0] seq [22] = '{
            8'h00, 8'hFF, 8'h41,
            8'h42, 8'h00, 8'h00, 8'h00,
            8'h42, 8'h00, 8'hFF, 8'hFF,
            8'h42, 8'h02, 8'hFF, 8'h42, 8'h01, 8'h41,
            8'h42, 8'h01, 8'h00, 8'h00, 8'h01
        };
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_pause_mid_frame();
        send_byte(sync_value);
        send_byte(8'h03);
        send_byte(8'h10);
        wait_idle();
        send_byte(8'h20);
        send_byte(8'h30);
        wait_idle();
        send_byte(8'h00);
        send_byte(8'h60);
    endtask

    task automatic test_longest_frame();
        send_byte(sync_value);
        send_byte(8'hFF);
        repeat (255) send_byte(8'hFF);
        send_byte(8'hFE);
        send_byte(8'h01);
    endtask

    task automatic test_random_stream(input int n_items);
        int stop_at;
        int r;
        int len;
        stop_at = sent_count + n_items;
        while (sent_count < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
                r = $urandom_range(0, 99);
                if (r < 3) len = 255;
                else if (r < 8) len = $urandom_range(13, 64);
                else len = $urandom_range(0, 12);
                send_frame(len, $urandom_range(0, 4) == 0);
            end else if (r < 90) begin
                // truncated frame, the bytes after it get swallowed as payload
                send_byte(sync_value);
                send_byte(8'($urandom_range(1, 12)));
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_rx_byte      = 8'h00;
        i_sync_byte_we = 1'b0;
        i_sync_byte    = 8'h00;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 35;
        recv_idle_pct = 57;
        test_directed_frames();
        test_pause_mid_frame();
        test_longest_frame();
        set_sync_byte(8'h00);
        test_random_stream(170);

        send_idle_pct = 57;
        recv_idle_pct = 35;
        set_sync_byte(8'hFF);
        test_random_stream(170);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_sync_byte(8'($urandom_range(1, 254)));
        test_random_stream(170);

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (err_count == 0 && expected_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
